// ----- rtl/dig_pkg.sv -----
// Shared types and constants for the duplicate index grouper.
package dig_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DRAIN  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_PAST_END = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SEARCH = 7'b0000010,
        S_CMP    = 7'b0000100,
        S_LINK   = 7'b0001000,
        S_DRD    = 7'b0010000,
        S_DOUT   = 7'b0100000,
        S_DNEXT  = 7'b1000000
    } state_t;

endpackage

// ----- rtl/duplicate_index_grouper_top.sv -----
// Top level of the duplicate index grouper: sequencer, key search and member lists.
// Insert: linear key scan over the G groups in the batch (S_SEARCH and S_CMP in turn), then S_LINK.
// Drain of an entry: S_DNEXT (group table read), S_DRD (head load, member link read), then S_DOUT.
// Closing drain, past-end drain, insert into a full table, clear, unused code: done straight from idle.
// busy is high from an accepted insert or entry drain until its result strobe; the receiver cannot stall.
// Reset clears counts, drain state and mode (use_column_key = 1); tables are not cleared.
module duplicate_index_grouper_top
    import dig_pkg::*;
#(
    parameter int CAPACITY   = 1024,
    parameter int INDEX_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [31:0] row_index,
    input  logic [31:0] col_index,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    output logic        done,
    output logic [9:0]  group_id,
    output logic        is_new,
    output logic [9:0]  item_position,
    output logic [31:0] unique_row,
    output logic [31:0] unique_col,
    output logic [10:0] group_offset,
    output logic        first_of_group,
    output logic        end_of_list,
    output logic [1:0]  status
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;
    localparam int KW = (INDEX_BITS < 32) ? INDEX_BITS : 32;

    // key comparison uses low INDEX_BITS, and only 32 input bits exist
    logic [KW-1:0] key_rows_mem [CAPACITY];
    logic [KW-1:0] key_cols_mem [CAPACITY];
    logic [AW-1:0] head_mem [CAPACITY];
    logic [AW-1:0] tail_mem [CAPACITY];
    logic [AW-1:0] next_mem [CAPACITY];

    state_t        state_reg;
    logic          mode_reg;
    logic [CW-1:0] item_count_reg, group_count_reg, drain_group_reg, drain_offset_reg;
    logic [CW-1:0] group_start_reg, scan_reg;
    logic [AW-1:0] drain_member_reg;
    logic          drain_active_reg;
    logic          at_head_reg;
    logic [KW-1:0] row_reg, col_reg;
    logic [KW-1:0] rd_row_reg, rd_col_reg;
    logic [AW-1:0] rd_head_reg, rd_tail_reg, rd_next_reg;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    logic [AW-1:0] scan_a;
    assign scan_a = scan_reg[AW-1:0];

    // follow the link of the group head while it is being loaded
    logic [AW-1:0] next_rd_a;
    assign next_rd_a = at_head_reg ? rd_head_reg : drain_member_reg;

    // registered table reads: keys, head and tail at the scan address, next link at next_rd_a
    always_ff @(posedge clk)
    begin
        rd_row_reg  <= key_rows_mem[scan_a];
        rd_col_reg  <= key_cols_mem[scan_a];
        rd_head_reg <= head_mem[scan_a];
        rd_tail_reg <= tail_mem[scan_a];
        rd_next_reg <= next_mem[next_rd_a];
    end

    logic wr_key, wr_tail, wr_next;
    logic [AW-1:0] pos_a;
    assign pos_a = item_count_reg[AW-1:0];

    // table writes
    always_ff @(posedge clk)
    begin
        if (wr_key)
        begin
            key_rows_mem[scan_a] <= row_reg;
            key_cols_mem[scan_a] <= col_reg;
            head_mem[scan_a]     <= pos_a;
        end
        if (wr_tail)
            tail_mem[scan_a] <= pos_a;
        if (wr_next)
            next_mem[rd_tail_reg] <= pos_a;
    end

    logic hit;
    assign hit = (rd_row_reg == row_reg) && (rd_col_reg == col_reg);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg <= 1'b1;
            item_count_reg <= '0;
            group_count_reg <= '0;
            drain_group_reg <= '0;
            drain_offset_reg <= '0;
            group_start_reg <= '0;
            drain_member_reg <= '0;
            drain_active_reg <= 1'b0;
            at_head_reg <= 1'b0;
            scan_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
            done <= 1'b0;
            wr_key <= 1'b0;
            wr_tail <= 1'b0;
            wr_next <= 1'b0;
            group_id <= '0;
            is_new <= 1'b0;
            item_position <= '0;
            unique_row <= '0;
            unique_col <= '0;
            group_offset <= '0;
            first_of_group <= 1'b0;
            end_of_list <= 1'b0;
            status <= ST_OK;
        end
        else
        begin
            done <= 1'b0;
            wr_key <= 1'b0;
            wr_tail <= 1'b0;
            wr_next <= 1'b0;
            if (cfg_valid)
                mode_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        group_id <= '0; is_new <= 1'b0; item_position <= '0;
                        unique_row <= '0; unique_col <= '0; group_offset <= '0;
                        first_of_group <= 1'b0; end_of_list <= 1'b0; status <= ST_OK;
                        row_reg <= row_index[KW-1:0];
                        col_reg <= mode_reg ? col_index[KW-1:0] : '0;
                        scan_reg <= '0;
                        case (command)
                            CMD_INSERT:
                            begin
                                drain_active_reg <= 1'b0;
                                if (item_count_reg == CW'(CAPACITY))
                                begin
                                    status <= ST_FULL;
                                    done <= 1'b1;
                                end
                                else
                                    state_reg <= S_SEARCH;
                            end
                            CMD_DRAIN:
                            begin
                                if (!drain_active_reg)
                                begin
                                    drain_active_reg <= 1'b1;
                                    drain_group_reg <= '0;
                                    drain_offset_reg <= '0;
                                    group_start_reg <= '0;
                                    at_head_reg <= 1'b1;
                                    scan_reg <= '0;
                                    if (group_count_reg == '0)
                                    begin
                                        end_of_list <= 1'b1;
                                        drain_group_reg <= CW'(1);
                                        done <= 1'b1;
                                    end
                                    else
                                        state_reg <= S_DNEXT;
                                end
                                else if (drain_group_reg > group_count_reg)
                                begin
                                    status <= ST_PAST_END;
                                    done <= 1'b1;
                                end
                                else if (drain_group_reg == group_count_reg)
                                begin
                                    end_of_list <= 1'b1;
                                    group_offset <= drain_offset_reg;
                                    drain_group_reg <= group_count_reg + CW'(1);
                                    done <= 1'b1;
                                end
                                else
                                begin
                                    scan_reg <= drain_group_reg;
                                    state_reg <= S_DNEXT;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                item_count_reg <= '0;
                                group_count_reg <= '0;
                                drain_group_reg <= '0;
                                drain_offset_reg <= '0;
                                group_start_reg <= '0;
                                drain_member_reg <= '0;
                                drain_active_reg <= 1'b0;
                                done <= 1'b1;
                            end
                            default: done <= 1'b1;
                        endcase
                    end
                end
                S_SEARCH:
                begin
                    if (scan_reg == group_count_reg)
                    begin
                        wr_key <= 1'b1;
                        wr_tail <= 1'b1;
                        state_reg <= S_LINK;
                        is_new <= 1'b1;
                        group_count_reg <= group_count_reg + CW'(1);
                    end
                    else
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (hit)
                    begin
                        wr_tail <= 1'b1;
                        wr_next <= 1'b1;
                        state_reg <= S_LINK;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + CW'(1);
                        state_reg <= S_SEARCH;
                    end
                end
                S_LINK:
                begin
                    group_id <= 10'(scan_reg);
                    item_position <= 10'(item_count_reg);
                    unique_row <= 32'(row_reg);
                    unique_col <= 32'(col_reg);
                    item_count_reg <= item_count_reg + CW'(1);
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_DNEXT:
                begin
                    // table reads for the current group are issued here and registered for S_DRD
                    state_reg <= S_DRD;
                end
                S_DRD:
                begin
                    // load the group head when the walk enters a new group
                    if (at_head_reg)
                    begin
                        drain_member_reg <= rd_head_reg;
                        at_head_reg <= 1'b0;
                    end
                    state_reg <= S_DOUT;
                end
                S_DOUT:
                begin
                    group_id <= 10'(drain_group_reg);
                    item_position <= 10'(drain_member_reg);
                    unique_row <= 32'(rd_row_reg);
                    unique_col <= 32'(rd_col_reg);
                    if (drain_member_reg == rd_head_reg)
                    begin
                        first_of_group <= 1'b1;
                        group_start_reg <= drain_offset_reg;
                        group_offset <= 11'(drain_offset_reg);
                    end
                    else
                        group_offset <= 11'(group_start_reg);
                    drain_offset_reg <= drain_offset_reg + CW'(1);
                    if (drain_member_reg == rd_tail_reg)
                    begin
                        drain_group_reg <= drain_group_reg + CW'(1);
                        at_head_reg <= 1'b1;
                    end
                    else
                        drain_member_reg <= rd_next_reg;
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || $past(start)) else $error("stray done");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        item_count_reg <= CW'(CAPACITY)) else $error("count over capacity");
    a_groups: assert property (@(posedge clk) disable iff (!rst_n)
        group_count_reg <= item_count_reg + CW'(1)) else $error("groups exceed items");
`endif
endmodule
